### rtl/core/tss_pkg.sv
// Package for the two-stack shared-memory block.
// Holds sizes, operation and status codes, and the payload and command types.
// No dependencies.
package tss_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef struct packed {
        t_opcode             opcode;
        logic                side;
        logic signed [31:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  read_value;
        logic [1:0]          status;
        logic                is_full;
        logic                left_empty;
        logic                right_empty;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // memory access and count update
        logic form;   // load the output register
    } t_dp_cmd;

endpackage

### rtl/core/two_stacks_shared_memory.sv
// Two LIFO stacks in one shared 32-entry memory.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one push, pop or
// peek on the left stack (grows up from entry 0) or the right stack (grows
// down from the top entry). Output channel (o_out_valid / i_out_ready /
// o_out_item) returns one result item per input item, in order: read value,
// status (ok, overflow, underflow) and the full and empty flags after the op.
// Each accepted item passes through the controller sequence accept, memory
// access (registered read), output register load; the next item is accepted
// only after the previous one has been loaded into the output register.
// The output is a register: a new item is accepted while a result waits, and
// that item then holds in the controller until the result is taken.
// A stalled receiver keeps o_out_item stable while o_out_valid is high.
// Reset (synchronous, active low) empties both stacks and clears all valids;
// memory contents are not cleared and are only read after being pushed.
// Depends on tss_pkg, tss_ctrl, tss_datapath.
module two_stacks_shared_memory (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tss_pkg::t_out_item o_out_item
);
    import tss_pkg::*;

    t_dp_cmd cmd;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    tss_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

### rtl/core/tss_datapath.sv
// Datapath: item register, shared memory, stack counts and output register.
// Depends on tss_pkg.
module tss_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tss_pkg::t_dp_cmd   i_cmd,
    input  tss_pkg::t_in_item  i_in_item,
    output tss_pkg::t_out_item o_out_item
);
    import tss_pkg::*;

    t_in_item            r_item;
    logic [CNT_W-1:0]    r_left;
    logic [CNT_W-1:0]    r_right;
    logic [CNT_W-1:0]    n_left;
    logic [CNT_W-1:0]    n_right;
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                r_use_mem;
    logic [VALUE_W-1:0]  r_fill;
    t_status             r_status;
    t_out_item           r_out;

    logic                full;
    logic                sel_empty;
    logic                mem_we;
    logic                mem_re;
    logic [CNT_W-1:0]    addr_full;
    logic [ADDR_W-1:0]   mem_addr;
    logic                n_use_mem;
    logic [VALUE_W-1:0]  n_fill;
    t_status             n_status;

    assign full      = CNT_W'(r_left + r_right) == CNT_W'(DEPTH);
    assign sel_empty = (r_item.side == SIDE_RIGHT) ? (r_right == '0) : (r_left == '0);

    always_comb begin
        n_left    = r_left;
        n_right   = r_right;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        addr_full = '0;
        n_use_mem = 1'b0;
        n_fill    = '0;
        n_status  = ST_OK;
        case (r_item.opcode)
            OP_PUSH: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else if (r_item.side == SIDE_RIGHT) begin
                    mem_we    = 1'b1;
                    addr_full = CNT_W'(DEPTH - 1) - r_right;
                    n_right   = r_right + CNT_W'(1);
                end else begin
                    mem_we    = 1'b1;
                    addr_full = r_left;
                    n_left    = r_left + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (sel_empty) begin
                    n_status = ST_UNDERFLOW;
                    n_fill   = (r_item.opcode == OP_PEEK) ? '1 : '0;
                end else begin
                    mem_re    = 1'b1;
                    n_use_mem = 1'b1;
                    if (r_item.side == SIDE_RIGHT) begin
                        addr_full = CNT_W'(DEPTH) - r_right;
                        if (r_item.opcode == OP_POP) begin
                            n_right = r_right - CNT_W'(1);
                        end
                    end else begin
                        addr_full = r_left - CNT_W'(1);
                        if (r_item.opcode == OP_POP) begin
                            n_left = r_left - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign mem_addr = addr_full[ADDR_W-1:0];

    // shared memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[mem_addr] <= r_item.push_value[DATA_WIDTH-1:0];
        end
        if (i_cmd.exec && mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_cmd.exec) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_use_mem <= n_use_mem;
            r_fill    <= n_fill;
            r_status  <= n_status;
        end
        if (i_cmd.form) begin
            r_out.read_value  <= r_use_mem ? VALUE_W'($signed(r_rd_data)) : r_fill;
            r_out.status      <= r_status;
            r_out.is_full     <= full;
            r_out.left_empty  <= (r_left == '0);
            r_out.right_empty <= (r_right == '0);
        end
    end

    assign o_out_item = r_out;

endmodule

### rtl/core/tss_ctrl.sv
// Controller: sequences accept, execute and output load for each item.
// Depends on tss_pkg.
module tss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tss_pkg::t_dp_cmd o_cmd
);
    import tss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FORM
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // output register can take a new item if empty or being drained now
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.form = (r_state == S_FORM) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a drain in the same cycle as a load leaves valid set
            if (r_out_valid && i_out_ready && !o_cmd.form) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_FORM;
                end
                S_FORM: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
